[hw/rtl/sle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  // Character codes
  localparam logic [7:0] ChrBs     = 8'd8;
  localparam logic [7:0] ChrLf     = 8'd10;
  localparam logic [7:0] ChrCr     = 8'd13;
  localparam logic [7:0] ChrCan    = 8'd24;
  localparam logic [7:0] ChrEsc    = 8'd27;
  localparam logic [7:0] ChrSpace  = 8'd32;
  localparam logic [7:0] ChrCaret  = 8'd94;
  localparam logic [7:0] ChrX      = 8'd88;
  localparam logic [7:0] ChrPrompt = 8'd62;

  localparam logic [7:0] MaxLengthReset = 8'd40;

  // Command queue between front and back
  localparam int unsigned CmdQueueDepth = 2;

  // Expansion step counter, enough for the six-beat cancel echo
  localparam int unsigned StepW = 3;

  typedef enum logic [1:0] {
    OP_RETURN,
    OP_CHAR,
    OP_BKSP,
    OP_CANCEL
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
    logic [7:0] index;
  } cmd_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       line_done;
    logic       last;
  } res_t;

  // Echo sequence for cancel / escape: " ^X\n> "
  function automatic logic [7:0] cancel_echo(logic [StepW-1:0] step);
    logic [7:0] b;
    unique case (step)
      3'd0:    b = ChrSpace;
      3'd1:    b = ChrCaret;
      3'd2:    b = ChrX;
      3'd3:    b = ChrLf;
      3'd4:    b = ChrPrompt;
      3'd5:    b = ChrSpace;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sle_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module sle_front
  import sle_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       max_length_we_i,
  input  wire logic [7:0] max_length_i,
  input  wire logic       cmd_full_i,
  output logic            cmd_push_o,
  output cmd_t            cmd_o
);

  logic [7:0] max_length_q;
  logic [7:0] line_length_q, line_length_d;
  logic       is_cr, is_print, is_bs, is_can, hit, accept;

  // Classify the incoming byte against the current line state
  always_comb begin
    is_cr    = (rx_byte_i == ChrCr);
    is_print = (rx_byte_i >= ChrSpace) && (line_length_q < max_length_q);
    is_bs    = (rx_byte_i == ChrBs) && (line_length_q != 8'd0);
    is_can   = (rx_byte_i == ChrCan) || (rx_byte_i == ChrEsc);
    hit      = is_cr || is_print || is_bs || is_can;
  end

  assign accept     = push_i && !cmd_full_i;
  assign full_o     = cmd_full_i;
  assign cmd_push_o = accept && hit;

  // Command for the back end; ignored bytes produce none
  always_comb begin
    cmd_o.data  = rx_byte_i;
    cmd_o.index = line_length_q;
    if (is_cr) begin
      cmd_o.op = OP_RETURN;
    end else if (is_print) begin
      cmd_o.op = OP_CHAR;
    end else if (is_bs) begin
      cmd_o.op = OP_BKSP;
    end else begin
      cmd_o.op = OP_CANCEL;
    end
  end

  // Line length update
  always_comb begin
    line_length_d = line_length_q;
    if (accept) begin
      if (is_cr || (!is_print && is_can)) begin
        line_length_d = 8'd0;
      end else if (is_print) begin
        line_length_d = line_length_q + 8'd1;
      end else if (is_bs) begin
        line_length_d = line_length_q - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= 8'd0;
      max_length_q  <= MaxLengthReset;
    end else begin
      line_length_q <= line_length_d;
      if (max_length_we_i) begin
        max_length_q <= max_length_i;
      end
    end
  end

`ifndef SYNTHESIS
  a_cr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !cmd_full_i && rx_byte_i == ChrCr) |=> (line_length_q == 8'd0))
    else $error("line length not cleared after return");
`endif

endmodule

`default_nettype wire

[hw/rtl/sle_cmd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module sle_cmd_fifo
  import sle_pkg::*;
#(
  parameter int unsigned Depth = CmdQueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t wdata_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      rdata_o,
  output logic      valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t             mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             wr_en, rd_en;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && valid_o;
  assign rdata_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (rd_en) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("command queue count out of range");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command queue popped while empty");
`endif

endmodule

`default_nettype wire

[hw/rtl/sle_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module sle_back
  import sle_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output res_t      res_o
);

  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q;
  res_t             out_q;
  res_t             res;
  logic             load;

  // Result for the current command and step
  always_comb begin
    res = '0;
    res.echo_valid = 1'b1;
    unique case (cmd_i.op)
      OP_RETURN: begin
        if (step_q == '0) begin
          res.echo_byte   = ChrCr;
          res.store_valid = 1'b1;
          res.store_index = cmd_i.index;
          res.line_done   = 1'b1;
        end else begin
          res.echo_byte = ChrLf;
          res.last      = 1'b1;
        end
      end
      OP_CHAR: begin
        res.echo_byte   = cmd_i.data;
        res.store_valid = 1'b1;
        res.store_index = cmd_i.index;
        res.store_byte  = cmd_i.data;
        res.last        = 1'b1;
      end
      OP_BKSP: begin
        res.echo_byte = (step_q == StepW'(1)) ? ChrSpace : ChrBs;
        res.last      = (step_q == StepW'(2));
      end
      OP_CANCEL: begin
        res.echo_byte = cancel_echo(step_q);
        res.last      = (step_q == StepW'(5));
      end
      default: res = '0;
    endcase
  end

  // Output register takes a new beat when empty or being drained
  assign load      = cmd_valid_i && (!out_valid_q || pop_i);
  assign cmd_pop_o = load && res.last;
  assign empty_o   = !out_valid_q;
  assign res_o     = out_q;

  always_comb begin
    step_d = step_q;
    if (load) begin
      step_d = res.last ? '0 : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepW'(5))
    else $error("expansion step out of range");
  a_step_holds_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != '0) |-> cmd_valid_i)
    else $error("command left the queue mid-expansion");
`endif

endmodule

`default_nettype wire

[hw/rtl/serial_line_editor.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake          Payload
// -------   ----------------   -----------------------------------------------
// input     push / full        rx_byte_i
// result    empty / pop        echo_*_o, store_*_o, line_done_o, last_o
// config    max_length_we_i    max_length_i
//
// A byte is accepted in any cycle with room in the two-entry command queue.
// The back end expands each command into output beats: return gives 2 beats,
// a printable byte 1, backspace 3, cancel/escape 6; ignored bytes give none.
// A beat passes through the command queue and then the output register; sustained rate is set by the expander.
// Reset (rst_ni, async, low) clears line length, sets max length to 40, empties queues.
// A stalled result port fills the queue and then raises full.

module serial_line_editor
  import sle_pkg::*;
#(
  parameter int unsigned QueueDepth = CmdQueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       max_length_we_i,
  input  wire logic [7:0] max_length_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            echo_valid_o,
  output logic [7:0]      echo_byte_o,
  output logic            store_valid_o,
  output logic [7:0]      store_index_o,
  output logic [7:0]      store_byte_o,
  output logic            line_done_o,
  output logic            last_o
);

  logic cmd_push, cmd_full, cmd_valid, cmd_pop;
  cmd_t cmd_in, cmd_out;
  res_t res;

  // Front: accept and classify
  sle_front u_front (
    .clk_i,
    .rst_ni,
    .push_i          (push),
    .full_o          (full),
    .rx_byte_i,
    .max_length_we_i,
    .max_length_i,
    .cmd_full_i      (cmd_full),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in)
  );

  // Command queue
  sle_cmd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .valid_o (cmd_valid)
  );

  // Back: expand commands into result beats
  sle_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign echo_valid_o  = res.echo_valid;
  assign echo_byte_o   = res.echo_byte;
  assign store_valid_o = res.store_valid;
  assign store_index_o = res.store_index;
  assign store_byte_o  = res.store_byte;
  assign line_done_o   = res.line_done;
  assign last_o        = res.last;

endmodule

`default_nettype wire
